// ===== design/ssoq_pkg.sv =====
// Package for the segment/sphere obstacle query block.
// Holds the command codes, controller states and controller/datapath structs.
`default_nettype none
package ssoq_pkg;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_CLOSEST = 2'd1;
   localparam logic [1:0] CMD_FIRST   = 2'd2;
   localparam logic [1:0] CMD_POINT   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } state_type;

   // per-entry evaluation steps in the datapath
   typedef enum logic [2:0] {
      EV_IDLE, EV_DOT, EV_SUM, EV_DIV, EV_CLOSE, EV_SQ, EV_CMP
   } ev_type;

   typedef struct packed {
      logic start;      // latch request, clear best
      logic div_step;   // add one len2 square term
      logic read;       // table read strobe; unused, the read address is the scan index
      logic eval_a;     // start the entry: deltas, then products
      logic eval_b;     // squares (never set; the datapath sequencer does them)
      logic eval_c;     // sum and compare (never set; the datapath sequencer does them)
      logic next_entry; // advance scan index
      logic finish;     // build result
   } ctl_type;

   typedef struct packed {
      logic is_load;
      logic scan_end;
      logic div_end;
      logic stop;       // first-hit or point query found an entry
      logic eval_done;  // entry evaluation finished
   } sts_type;

endpackage
`default_nettype wire

// ===== design/segment_sphere_obstacle_query.sv =====
// Segment/sphere obstacle query block.
// A request with cmd load writes one table entry (centre, radius, owner) and
// is acknowledged with hit=1 and the slot. A closest, first-hit or point
// request scans entries 0..obstacle_count-1 in order and returns one response.
// Channels: req_* in, rsp_* out, valid/stall on each; a request is taken when
// req_valid is high and req_stall low, a response when rsp_valid is high and
// rsp_stall low. csr_wr_en/csr_wr_data write obstacle_count; write it only
// while idle.
// A scan stops at MAX_OBSTACLES entries when obstacle_count is larger; a
// first-hit or point query stops at its first hit. The serial divider for
// t runs per scanned entry and is skipped when t clamps to 0 or 1.
// One request is in flight at a time; the next request can be taken in the
// cycle after the response is taken.
// Reset clears the controller and obstacle_count; table entries stay
// undefined until loaded. While rsp_stall is high the response holds and no
// new request is taken.
`default_nettype none
module segment_sphere_obstacle_query #(
   parameter int MAX_OBSTACLES = 64,
   parameter int COORD_BITS    = 24,
   parameter int T_FRAC_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [6:0]            csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [5:0]            req_slot,
   input  wire logic signed [COORD_BITS-1:0] req_ax,
   input  wire logic signed [COORD_BITS-1:0] req_ay,
   input  wire logic signed [COORD_BITS-1:0] req_az,
   input  wire logic signed [COORD_BITS-1:0] req_bx,
   input  wire logic signed [COORD_BITS-1:0] req_by,
   input  wire logic signed [COORD_BITS-1:0] req_bz,
   input  wire logic [COORD_BITS-2:0] req_radius,
   input  wire logic [15:0]           req_owner_tag,
   input  wire logic [15:0]           req_ignore_tag,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [5:0]                 rsp_obstacle_index,
   output logic [49:0]                rsp_distance_sq
);
   logic [6:0] count_ff;
   ssoq_pkg::ctl_type ctl;
   ssoq_pkg::sts_type sts;

   // obstacle_count register
   always_ff @(posedge clock) begin
      if (reset) count_ff <= 7'd0;
      else if (csr_wr_en) count_ff <= csr_wr_data;
   end

   ssoq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .ctl);

   ssoq_dp #(.MAX_OBSTACLES(MAX_OBSTACLES), .COORD_BITS(COORD_BITS),
             .T_FRAC_BITS(T_FRAC_BITS)) u_dp (
      .clock, .reset, .ctl, .sts, .count(count_ff),
      .req_cmd, .req_slot, .req_ax, .req_ay, .req_az, .req_bx, .req_by, .req_bz,
      .req_radius, .req_owner_tag, .req_ignore_tag,
      .rsp_hit, .rsp_obstacle_index, .rsp_distance_sq);

   // a response never carries a miss with a nonzero index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_obstacle_index == 6'd0 && rsp_distance_sq == 50'd0)
      else $error("miss response with nonzero payload");

   // no request is taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with response pending");
endmodule
`default_nettype wire

// ===== design/ssoq_ram.sv =====
// Generic single-port-write RAM with a registered read.
// No dependencies.
`default_nettype none
module ssoq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/ssoq_ctrl.sv =====
// Controller state machine for the obstacle query block.
// Uses ssoq_pkg for states and the command/status structs.
`default_nettype none
module ssoq_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire ssoq_pkg::sts_type sts,
   output ssoq_pkg::ctl_type   ctl
);
   ssoq_pkg::state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ssoq_pkg::ST_IDLE: begin
            if (req_valid) state_in = ssoq_pkg::ST_SETUP;
         end
         ssoq_pkg::ST_SETUP: begin
            if (sts.is_load) state_in = ssoq_pkg::ST_DONE;
            else             state_in = ssoq_pkg::ST_DIV;
         end
         ssoq_pkg::ST_DIV: begin
            if (sts.div_end) state_in = ssoq_pkg::ST_READ;
         end
         ssoq_pkg::ST_READ: begin
            phase_in = 2'd0;
            if (sts.scan_end) state_in = ssoq_pkg::ST_DONE;
            else              state_in = ssoq_pkg::ST_EVAL;
         end
         ssoq_pkg::ST_EVAL: begin
            phase_in = 2'd1;
            // wait for the datapath to finish the entry
            if (phase_ff != 2'd0 && sts.eval_done) begin
               if (sts.stop) state_in = ssoq_pkg::ST_DONE;
               else          state_in = ssoq_pkg::ST_READ;
            end
         end
         ssoq_pkg::ST_DONE: begin
            if (rsp_valid_ff && !rsp_stall) state_in = ssoq_pkg::ST_IDLE;
         end
         default: state_in = ssoq_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall = 1'b1;
      case (state_ff)
         ssoq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.start = req_valid;
         end
         ssoq_pkg::ST_DIV:   ctl.div_step = 1'b1;
         ssoq_pkg::ST_READ:  ctl.read = !sts.scan_end;
         ssoq_pkg::ST_EVAL: begin
            ctl.eval_a     = (phase_ff == 2'd0);
            ctl.next_entry = (phase_ff != 2'd0) && sts.eval_done;
         end
         ssoq_pkg::ST_DONE: begin
            if (!rsp_valid_ff) begin
               ctl.finish = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssoq_pkg::ST_IDLE;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/ssoq_dp.sv =====
// Datapath: obstacle tables, segment parameter divider and distance pipeline.
// Uses ssoq_pkg and ssoq_ram.
`default_nettype none
module ssoq_dp #(
   parameter int MAX_OBSTACLES = 64,
   parameter int COORD_BITS    = 24,
   parameter int T_FRAC_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ssoq_pkg::ctl_type     ctl,
   output ssoq_pkg::sts_type          sts,
   input  wire logic [6:0]            count,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [5:0]            req_slot,
   input  wire logic signed [COORD_BITS-1:0] req_ax,
   input  wire logic signed [COORD_BITS-1:0] req_ay,
   input  wire logic signed [COORD_BITS-1:0] req_az,
   input  wire logic signed [COORD_BITS-1:0] req_bx,
   input  wire logic signed [COORD_BITS-1:0] req_by,
   input  wire logic signed [COORD_BITS-1:0] req_bz,
   input  wire logic [COORD_BITS-2:0] req_radius,
   input  wire logic [15:0]           req_owner_tag,
   input  wire logic [15:0]           req_ignore_tag,
   output logic                       rsp_hit,
   output logic [5:0]                 rsp_obstacle_index,
   output logic [49:0]                rsp_distance_sq
);
   localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CW = AW + 1;
   localparam int DW = COORD_BITS + 1;          // delta width
   localparam int PW = 2 * DW;                  // product width
   localparam int SW = PW + 2;                  // three-term sum width
   localparam int TW = T_FRAC_BITS + 1;
   localparam int MW = DW + TW;                 // delta * t
   localparam int QW = $clog2(T_FRAC_BITS + 2);

   // request registers
   logic [1:0]                  cmd_ff;
   logic [5:0]                  slot_ff;
   logic signed [COORD_BITS-1:0] a_ff [3];
   logic signed [DW-1:0]        ab_ff [3];
   logic [15:0]                 ign_ff;
   logic [CW-1:0]               lim_ff;

   // obstacle tables, all written at load
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               scan_ff;
   logic signed [COORD_BITS-1:0] cx_rd, cy_rd, cz_rd;
   logic [COORD_BITS-2:0]       r_rd;
   logic [15:0]                 own_rd;

   assign wr_en   = ctl.start && (req_cmd == ssoq_pkg::CMD_LOAD) &&
                    ({26'd0, req_slot} < 32'(MAX_OBSTACLES));
   assign wr_addr = AW'(req_slot);

   ssoq_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_OBSTACLES)) u_cx (
      .clock, .wr_en, .wr_addr, .wr_data(req_ax), .rd_addr(idx_ff), .rd_data(cx_rd));
   ssoq_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_OBSTACLES)) u_cy (
      .clock, .wr_en, .wr_addr, .wr_data(req_ay), .rd_addr(idx_ff), .rd_data(cy_rd));
   ssoq_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_OBSTACLES)) u_cz (
      .clock, .wr_en, .wr_addr, .wr_data(req_az), .rd_addr(idx_ff), .rd_data(cz_rd));
   ssoq_ram #(.WIDTH(COORD_BITS-1), .DEPTH(MAX_OBSTACLES)) u_rad (
      .clock, .wr_en, .wr_addr, .wr_data(req_radius), .rd_addr(idx_ff), .rd_data(r_rd));
   ssoq_ram #(.WIDTH(16), .DEPTH(MAX_OBSTACLES)) u_own (
      .clock, .wr_en, .wr_addr, .wr_data(req_owner_tag), .rd_addr(idx_ff), .rd_data(own_rd));

   // latch request
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cmd_ff   <= req_cmd;
         slot_ff  <= req_slot;
         a_ff[0]  <= req_ax;
         a_ff[1]  <= req_ay;
         a_ff[2]  <= req_az;
         ign_ff   <= req_ignore_tag;
         if (req_cmd == ssoq_pkg::CMD_POINT) begin
            ab_ff[0] <= '0;
            ab_ff[1] <= '0;
            ab_ff[2] <= '0;
         end else begin
            ab_ff[0] <= DW'(req_bx) - DW'(req_ax);
            ab_ff[1] <= DW'(req_by) - DW'(req_ay);
            ab_ff[2] <= DW'(req_bz) - DW'(req_az);
         end
         if ({25'd0, count} > 32'(MAX_OBSTACLES)) lim_ff <= CW'(MAX_OBSTACLES);
         else                                     lim_ff <= CW'(count);
      end
   end

   // scan index
   assign idx_in = ctl.next_entry ? idx_ff + AW'(1) : idx_ff;
   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         idx_ff  <= '0;
         scan_ff <= '0;
      end else if (ctl.next_entry) begin
         idx_ff  <= idx_in;
         scan_ff <= scan_ff + CW'(1);
      end
   end

   // evaluation pipeline: products/deltas, squares, sum and compare
   logic signed [DW-1:0]  d_ff [3];      // c - a
   logic signed [MW-1:0]  m_ff [3];      // ab * t
   logic [2*(COORD_BITS-1)-1:0] r2_ff;
   logic                  skip_ff;
   logic signed [DW:0]    e_ff [3];      // c - closest
   logic [PW+1:0]         sq_ff [3];
   logic [SW:0]           dist_ff;

   // len2 is accumulated once per request before the scan; dot terms are
   // evaluated per-entry since dot depends on the centre.
   logic signed [PW-1:0]  dot_ff [3];
   logic [SW-1:0]         len2_ff;
   logic [TW-1:0]         t_ff;

   // len2 once per request: sequential squares during divider slot
   logic [QW-1:0]         div_cnt_ff;
   logic [1:0]            l2_cnt_ff;

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         len2_ff    <= '0;
         l2_cnt_ff  <= '0;
         div_cnt_ff <= '0;
      end else if (ctl.div_step) begin
         if (l2_cnt_ff != 2'd3) begin
            len2_ff   <= len2_ff + SW'($unsigned(PW'(ab_ff[l2_cnt_ff]) *
                                                 PW'(ab_ff[l2_cnt_ff])));
            l2_cnt_ff <= l2_cnt_ff + 2'd1;
         end
      end
   end

   // per-entry divider for t
   logic [SW-1:0] pos_ff, neg_ff, num_ff, rem_ff;
   logic [QW-1:0] bit_ff;
   logic          div_busy_ff;
   logic [3:0]    step_ff;

   ssoq_pkg::ev_type ev_ff;

   // found / best
   logic          found_ff;
   logic [AW-1:0] best_idx_ff;
   logic [SW:0]   best_d_ff;
   logic          stop_ff;
   logic          hitc;
   logic [SW-1:0] gap;

   assign gap  = len2_ff - rem_ff;
   assign hitc = (dist_ff <= (SW+1)'(r2_ff));

   // per-entry sub-sequencer; the controller waits in EVAL until it is idle again
   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         ev_ff    <= ssoq_pkg::EV_IDLE;
         found_ff <= 1'b0;
         stop_ff  <= 1'b0;
         best_idx_ff <= '0;
         best_d_ff   <= '0;
      end else begin
         case (ev_ff)
            ssoq_pkg::EV_IDLE: if (ctl.eval_a) begin
               d_ff[0] <= DW'(cx_rd) - DW'(a_ff[0]);
               d_ff[1] <= DW'(cy_rd) - DW'(a_ff[1]);
               d_ff[2] <= DW'(cz_rd) - DW'(a_ff[2]);
               r2_ff   <= (2*(COORD_BITS-1))'(r_rd) * (2*(COORD_BITS-1))'(r_rd);
               skip_ff <= (cmd_ff != ssoq_pkg::CMD_CLOSEST) && (ign_ff != 16'd0) &&
                          (own_rd == ign_ff);
               ev_ff   <= ssoq_pkg::EV_DOT;
               step_ff <= '0;
            end
            ssoq_pkg::EV_DOT: begin
               dot_ff[step_ff[1:0]] <= d_ff[step_ff[1:0]] * ab_ff[step_ff[1:0]];
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd2) begin
                  ev_ff <= ssoq_pkg::EV_SUM;
               end
            end
            ssoq_pkg::EV_SUM: begin
               pos_ff <= SW'((dot_ff[0] >= 0) ? $unsigned(dot_ff[0]) : '0) +
                         SW'((dot_ff[1] >= 0) ? $unsigned(dot_ff[1]) : '0) +
                         SW'((dot_ff[2] >= 0) ? $unsigned(dot_ff[2]) : '0);
               neg_ff <= SW'((dot_ff[0] < 0) ? $unsigned(-dot_ff[0]) : '0) +
                         SW'((dot_ff[1] < 0) ? $unsigned(-dot_ff[1]) : '0) +
                         SW'((dot_ff[2] < 0) ? $unsigned(-dot_ff[2]) : '0);
               ev_ff  <= ssoq_pkg::EV_DIV;
               bit_ff <= '0;
               div_busy_ff <= 1'b0;
            end
            ssoq_pkg::EV_DIV: begin
               if (!div_busy_ff) begin
                  num_ff <= pos_ff - neg_ff;
                  rem_ff <= pos_ff - neg_ff;
                  t_ff   <= '0;
                  div_busy_ff <= 1'b1;
                  if (len2_ff == '0 || pos_ff <= neg_ff) begin
                     ev_ff <= ssoq_pkg::EV_CLOSE;
                     step_ff <= '0;
                  end else if (pos_ff - neg_ff >= len2_ff) begin
                     t_ff  <= TW'(1) << T_FRAC_BITS;
                     ev_ff <= ssoq_pkg::EV_CLOSE;
                     step_ff <= '0;
                  end
               end else begin
                  // restoring step on the gap form
                  if (rem_ff >= gap) begin
                     rem_ff <= rem_ff - gap;
                     t_ff   <= {t_ff[TW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_ff << 1;
                     t_ff   <= {t_ff[TW-2:0], 1'b0};
                  end
                  bit_ff <= bit_ff + QW'(1);
                  if (bit_ff == QW'(T_FRAC_BITS - 1)) begin
                     ev_ff   <= ssoq_pkg::EV_CLOSE;
                     step_ff <= '0;
                  end
               end
            end
            ssoq_pkg::EV_CLOSE: begin
               m_ff[step_ff[1:0]] <= MW'(ab_ff[step_ff[1:0]]) *
                                     $signed({1'b0, t_ff});
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd2) begin
                  ev_ff   <= ssoq_pkg::EV_SQ;
                  step_ff <= '0;
               end
            end
            ssoq_pkg::EV_SQ: begin
               // floor shift is an arithmetic shift; c - (a + s) = d - s
               if (step_ff != 4'd3) begin
                  e_ff[step_ff[1:0]] <= (DW+1)'(d_ff[step_ff[1:0]]) -
                                        (DW+1)'(m_ff[step_ff[1:0]] >>> T_FRAC_BITS);
               end
               if (step_ff != 4'd0) begin
                  sq_ff[step_ff[1:0] - 2'd1] <= (PW+2)'($unsigned(
                     (PW+2)'(e_ff[step_ff[1:0] - 2'd1]) *
                     (PW+2)'(e_ff[step_ff[1:0] - 2'd1])));
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd3) begin
                  ev_ff <= ssoq_pkg::EV_CMP;
                  step_ff <= '0;
               end
            end
            ssoq_pkg::EV_CMP: begin
               if (step_ff == 4'd0) begin
                  sq_ff[2] <= (PW+2)'($unsigned((PW+2)'(e_ff[2]) * (PW+2)'(e_ff[2])));
                  step_ff  <= 4'd1;
               end else if (step_ff == 4'd1) begin
                  dist_ff <= (SW+1)'(sq_ff[0]) + (SW+1)'(sq_ff[1]) + (SW+1)'(sq_ff[2]);
                  step_ff <= 4'd2;
               end else begin
                  if (!skip_ff && hitc) begin
                     if (cmd_ff == ssoq_pkg::CMD_CLOSEST) begin
                        if (!found_ff || dist_ff < best_d_ff) begin
                           best_d_ff   <= dist_ff;
                           best_idx_ff <= idx_ff;
                        end
                        found_ff <= 1'b1;
                     end else begin
                        found_ff    <= 1'b1;
                        best_idx_ff <= idx_ff;
                        stop_ff     <= 1'b1;
                     end
                  end
                  ev_ff <= ssoq_pkg::EV_IDLE;
               end
            end
            default: ev_ff <= ssoq_pkg::EV_IDLE;
         endcase
      end
   end

   logic ev_done;
   assign ev_done = (ev_ff == ssoq_pkg::EV_IDLE);

   // status
   assign sts.is_load   = (cmd_ff == ssoq_pkg::CMD_LOAD);
   assign sts.div_end   = (l2_cnt_ff == 2'd3);
   assign sts.scan_end  = (scan_ff >= lim_ff) || stop_ff;
   assign sts.stop      = stop_ff;
   assign sts.eval_done = ev_done;

   // result register
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         if (cmd_ff == ssoq_pkg::CMD_LOAD) begin
            rsp_hit            <= 1'b1;
            rsp_obstacle_index <= slot_ff;
            rsp_distance_sq    <= '0;
         end else begin
            rsp_hit            <= found_ff;
            rsp_obstacle_index <= found_ff ? 6'(best_idx_ff) : 6'd0;
            rsp_distance_sq    <= (found_ff && cmd_ff == ssoq_pkg::CMD_CLOSEST) ?
                                  50'(best_d_ff) : 50'd0;
         end
      end
   end

   // unused intermediate
   logic unused_ok;
   assign unused_ok = ^{num_ff, div_cnt_ff, idx_in, ctl.eval_b, ctl.eval_c, ctl.read};
endmodule
`default_nettype wire
